// ===== hdl/wpst_pkg.sv =====
// Shared types, constants and field layout for the watchpoint slot table.
package wpst_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FLAG_CNT  = 4;

  // request codes
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;
  localparam logic [1:0] REQ_BAD   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INVAL  = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;

  // function and mask codes
  localparam logic [2:0] FN_FREE   = 3'd0;
  localparam logic [2:0] FN_READ   = 3'd5;
  localparam logic [2:0] FN_WRITE  = 3'd6;
  localparam logic [2:0] FN_ACCESS = 3'd7;
  localparam logic [1:0] MASK_BYTE = 2'd0;
  localparam logic [1:0] MASK_HALF = 2'd1;
  localparam logic [1:0] MASK_WORD = 2'd3;
  localparam logic [23:0] DATASIZE_WORD = 24'h000800;

  // access kinds and lengths
  localparam logic [7:0] KIND_WRITE  = 8'd2;
  localparam logic [7:0] KIND_READ   = 8'd3;
  localparam logic [7:0] KIND_ACCESS = 8'd4;
  localparam logic [7:0] LEN_BYTE    = 8'd1;
  localparam logic [7:0] LEN_HALF    = 8'd2;
  localparam logic [7:0] LEN_WORD    = 8'd4;

  // register indexes
  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_V6M   = 1'b1;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 96;

  typedef struct packed {
    logic load_req;
    logic execute;
  } wpst_cmd_t;

  typedef struct packed {
    logic out_full;
  } wpst_sts_t;

endpackage

// ===== hdl/wpst_ctrl.sv =====
// Request sequencer: accept, execute, hand off to the output register.
module wpst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  wpst_pkg::wpst_sts_t sts,
  output wpst_pkg::wpst_cmd_t cmd
);
  import wpst_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   rdy_r;

  always_comb begin
    cmd.load_req = in_tvalid && rdy_r;
    cmd.execute  = (state_r == S_EXEC) && !sts.out_full;
  end

  assign in_tready = rdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.load_req) begin
            state_r <= S_EXEC;
            rdy_r   <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd.execute) begin
            state_r <= S_IDLE;
            rdy_r   <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          rdy_r   <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hdl/wpst_dp.sv =====
// Slot table, request register, slot search and result register.
module wpst_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wpst_pkg::wpst_cmd_t                  cmd,
  output wpst_pkg::wpst_sts_t                  sts,
  input  logic [2:0]                           slots_in_use,
  input  logic                                 v6m_mode,
  input  logic [1:0]                           in_func,
  input  logic [wpst_pkg::IN_DATA_W-1:0]       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [wpst_pkg::OUT_DATA_W-1:0]      out_data
);
  import wpst_pkg::*;

  // request register
  logic [1:0]  func_r;
  logic [7:0]  kind_r;
  logic [31:0] addr_r;
  logic [7:0]  len_r;
  logic [3:0]  flags_r;

  // slot table
  logic [2:0]  slot_fn_r   [NUM_SLOTS];
  logic [31:0] slot_addr_r [NUM_SLOTS];
  logic [1:0]  slot_mask_r [NUM_SLOTS];

  // result register
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic        hit_r;
  logic [31:0] hit_addr_r;
  logic [1:0]  slot_idx_r;
  logic        we_r;
  logic [31:0] comp_r;
  logic [1:0]  mask_r;
  logic [23:0] fn_word_r;

  logic [1:0]  status_nxt;
  logic        hit_nxt;
  logic [31:0] hit_addr_nxt;
  logic [1:0]  slot_idx_nxt;
  logic        we_nxt;
  logic [31:0] comp_nxt;
  logic [1:0]  mask_nxt;
  logic [23:0] fn_word_nxt;

  logic              len_ok, kind_ok;
  logic [1:0]        mk;
  logic [2:0]        fn;
  logic [NUM_SLOTS-1:0] hit_vec;
  logic [SLOT_W-1:0] idx;
  logic              found;
  logic              wr_set, wr_clr;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r  <= in_func;
      kind_r  <= in_data[7:0];
      addr_r  <= in_data[39:8];
      len_r   <= in_data[47:40];
      flags_r <= in_data[51:48];
    end
  end

  // argument decode
  always_comb begin
    len_ok = 1'b1;
    mk     = MASK_BYTE;
    case (len_r)
      LEN_BYTE: mk = MASK_BYTE;
      LEN_HALF: mk = MASK_HALF;
      LEN_WORD: mk = MASK_WORD;
      default:  len_ok = 1'b0;
    endcase
    kind_ok = 1'b1;
    fn      = FN_FREE;
    case (kind_r)
      KIND_WRITE:  fn = FN_WRITE;
      KIND_READ:   fn = FN_READ;
      KIND_ACCESS: fn = FN_ACCESS;
      default:     kind_ok = 1'b0;
    endcase
  end

  // per-slot candidate vector, depends on request
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      logic active;
      active = (i < int'(slots_in_use));
      case (func_r)
        REQ_SET:   hit_vec[i] = active && (slot_fn_r[i] == FN_FREE);
        REQ_CLEAR: hit_vec[i] = active && (slot_fn_r[i] != FN_FREE) &&
                                (slot_fn_r[i] == fn) && (slot_addr_r[i] == addr_r) &&
                                (slot_mask_r[i] == mk);
        REQ_CHECK: hit_vec[i] = active && (i < FLAG_CNT) &&
                                (slot_fn_r[i] != FN_FREE) && flags_r[i % FLAG_CNT];
        default:   hit_vec[i] = 1'b0;
      endcase
    end
  end

  // lowest set candidate
  always_comb begin
    idx   = '0;
    found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        idx   = SLOT_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    status_nxt   = ST_OK;
    hit_nxt      = 1'b0;
    hit_addr_nxt = '0;
    slot_idx_nxt = '0;
    we_nxt       = 1'b0;
    comp_nxt     = '0;
    mask_nxt     = '0;
    fn_word_nxt  = '0;
    wr_set       = 1'b0;
    wr_clr       = 1'b0;
    case (func_r)
      REQ_CHECK: begin
        if (found) begin
          hit_nxt      = 1'b1;
          hit_addr_nxt = slot_addr_r[idx];
        end
      end
      REQ_SET, REQ_CLEAR: begin
        if (!(len_ok && kind_ok)) begin
          status_nxt = ST_INVAL;
        end else if (!found) begin
          status_nxt = ST_NOSLOT;
        end else begin
          slot_idx_nxt = 2'(idx);
          we_nxt       = 1'b1;
          if (func_r == REQ_SET) begin
            wr_set      = 1'b1;
            comp_nxt    = addr_r;
            mask_nxt    = mk;
            fn_word_nxt = {21'd0, fn} | (v6m_mode ? 24'd0 : DATASIZE_WORD);
          end else begin
            wr_clr   = 1'b1;
            comp_nxt = slot_addr_r[idx];
            mask_nxt = slot_mask_r[idx];
          end
        end
      end
      default: status_nxt = ST_INVAL;
    endcase
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_fn_r[i]   <= FN_FREE;
        slot_addr_r[i] <= '0;
        slot_mask_r[i] <= MASK_BYTE;
      end
    end else if (cmd.execute) begin
      if (wr_set) begin
        slot_fn_r[idx]   <= fn;
        slot_addr_r[idx] <= addr_r;
        slot_mask_r[idx] <= mk;
      end else if (wr_clr) begin
        slot_fn_r[idx] <= FN_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.execute) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r   <= status_nxt;
      hit_r      <= hit_nxt;
      hit_addr_r <= hit_addr_nxt;
      slot_idx_r <= slot_idx_nxt;
      we_r       <= we_nxt;
      comp_r     <= comp_nxt;
      mask_r     <= mask_nxt;
      fn_word_r  <= fn_word_nxt;
    end
  end

  assign sts.out_full = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_data     = {2'b00, fn_word_r, mask_r, comp_r, we_r, slot_idx_r,
                         hit_addr_r, hit_r};

endmodule

// ===== hdl/watchpoint_comparator_slot_table.sv =====
// Top level of the watchpoint comparator slot table.
//
// Usage:
//   in_*  : request stream. in_tuser carries the request code (set, clear,
//           check); in_tdata carries kind, address, length and matched flags.
//   out_* : one result per request. out_tuser carries the status, out_tdata
//           the check result and the comparator words to write.
//   cfg_* : APB register port. Address 0: slots_in_use, address 4: v6m_mode.
// Flow: an accepted request is captured in the request register, then
//   searched and applied to the slot table in its execute step, which also
//   loads its result into the output register.
// Ordering: the accept/execute sequencer handles one request at a time
//   against the slot table; a new request waits until the last has executed.
// Stall: when out_tready is low the result is held in the output register;
//   a request already taken waits in its execute step until the register
//   drains, and in_tready stays low meanwhile.
// Reset: all slots free, slots_in_use = 4, v6m_mode = 0, no result pending.
module watchpoint_comparator_slot_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // access_kind[7:0], watch_address[39:8], length_bytes[47:40],
  // matched_flags[51:48], zero fill
  input  logic [wpst_pkg::IN_DATA_W-1:0]      in_tdata,
  // func[1:0]
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit[0], hit_address[32:1], slot_index[34:33], write_enable[35],
  // comparator_word[67:36], mask_word[69:68], function_word[93:70], zero fill
  output logic [wpst_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [2:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import wpst_pkg::*;

  wpst_cmd_t  cmd;
  wpst_sts_t  sts;
  logic [2:0] slots_r;
  logic       v6m_r;
  logic       cfg_wr;

  // Register file: written on the APB access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= 3'd4;
      v6m_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_SLOTS: slots_r <= cfg_pwdata[2:0];
        REG_V6M:   v6m_r   <= cfg_pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_SLOTS: cfg_prdata = {29'd0, slots_r};
      REG_V6M:   cfg_prdata = {31'd0, v6m_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Sequencer: takes a request, then gates its execute step on the
  // output register having room.
  wpst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request register, slot table, search and result register.
  wpst_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .slots_in_use (slots_r),
    .v6m_mode     (v6m_r),
    .in_func      (in_tuser),
    .in_data      (in_tdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_tuser),
    .out_data     (out_tdata)
  );

`ifndef SYNTHESIS
  // A taken request blocks the next one until it has executed.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // A new result only appears out of the execute step.
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without an executing request");

  // Comparator writes come only with an ok status.
  a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> !out_tdata[35])
    else $error("write enable set on a failed request");

  // A check never asks for a comparator write.
  a_check_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[35])
    else $error("hit reported together with a write");
`endif

endmodule
